>>> hw/rtl/rdlc_pkg.sv
// Shared types and constants of the relay delay and lockout controller.
package rdlc_pkg;

	localparam int MASK_W = 8;
	localparam int CNT_W = 16;
	localparam int CH_W = 4;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ON = 2'd1;
	localparam logic [1:0] OP_OFF = 2'd2;

	localparam logic [CNT_W-1:0] RECLOSE_RESET = 16'd30;

	typedef struct packed {
		logic [1:0] operation;
		logic [CH_W-1:0] channel;
		logic [CNT_W-1:0] delay_ticks;
	} cmd_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] drive_on_mask;
		logic [MASK_W-1:0] drive_off_mask;
		logic bad_channel;
	} res_item_t;

	typedef struct packed {
		logic tick;
		logic switch_on;
		logic switch_off;
	} chan_ctrl_t;

endpackage

>>> hw/rtl/rdlc_channel.sv
// State, per-tick update and switch handling of one relay channel.
module rdlc_channel
	import rdlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  chan_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] delay_ticks,
	input  logic [CNT_W-1:0] reclose_ticks,
	output logic             drive_on,
	output logic             drive_off
);

	logic             mode_on_q;
	logic             close_enabled_q;
	logic [CNT_W-1:0] on_delay_q;
	logic [CNT_W-1:0] off_delay_q;
	logic [CNT_W-1:0] lockout_q;

	assign drive_on = mode_on_q && (on_delay_q == '0) && close_enabled_q;
	assign drive_off = !mode_on_q && (off_delay_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_on_q <= 1'b0;
			close_enabled_q <= 1'b0;
			on_delay_q <= '0;
			off_delay_q <= '0;
			lockout_q <= '0;
		end else if (ctrl.tick) begin
			if (mode_on_q) begin
				if (on_delay_q != '0) begin
					on_delay_q <= on_delay_q - CNT_W'(1);
				end
			end else begin
				if (off_delay_q != '0) begin
					off_delay_q <= off_delay_q - CNT_W'(1);
				end
			end
			if (lockout_q != '0) begin
				lockout_q <= lockout_q - CNT_W'(1);
			end else begin
				close_enabled_q <= 1'b1;
			end
		end else if (ctrl.switch_on && !mode_on_q) begin
			mode_on_q <= 1'b1;
			on_delay_q <= delay_ticks;
		end else if (ctrl.switch_off && mode_on_q) begin
			mode_on_q <= 1'b0;
			off_delay_q <= delay_ticks;
			close_enabled_q <= 1'b0;
			lockout_q <= reclose_ticks;
		end
	end

endmodule

>>> hw/rtl/relay_delay_lockout_controller_unit.sv
// Top level of the relay delay and lockout controller.
//
// The cmd channel carries one item per tick or switching command; the res
// channel returns exactly one result item for every accepted cmd item.
// Both channels use valid and stall: an item moves on a rising edge where
// valid is high and stall is low.
// Every channel's state is updated at the edge where the cmd item is taken,
// and its result item is registered at that edge, in the skid register if
// the result register is held. Throughput is one item per cycle while cmd_stall
// is low; all channels are updated side by side by their own counters.
// When the receiver stalls, the result register holds and one further
// result is parked in a skid register; cmd_stall is raised only while the
// skid register is occupied, so two items may wait before input stops.
// The reclose lockout value is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// Asynchronous reset puts every channel in OFF mode with all counters at
// zero and close-enable cleared, empties both result registers and sets the
// lockout value to 30 ticks.
module relay_delay_lockout_controller_unit
	import rdlc_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_item_t        cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output res_item_t        res
);

	localparam int CMP_W = CH_W + 1;

	logic [CNT_W-1:0]    reclose_q;
	logic                cmd_fire;
	logic                res_fire;
	logic                is_tick;
	logic                is_cmd;
	logic                bad_ch;
	logic [CHANNELS-1:0] on_vec;
	logic [CHANNELS-1:0] off_vec;
	res_item_t           new_res;
	res_item_t           skid_q;
	logic                skid_valid_q;
	logic                res_valid_q;
	res_item_t           res_q;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign res_fire = res_valid_q && !res_stall;
	assign is_tick = cmd.operation == OP_TICK;
	assign is_cmd = (cmd.operation == OP_ON) || (cmd.operation == OP_OFF);
	assign bad_ch = is_cmd && ({1'b0, cmd.channel} >= CMP_W'(CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reclose_q <= RECLOSE_RESET;
		end else if (cfg_we) begin
			reclose_q <= cfg_wdata;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		chan_ctrl_t ctrl;

		assign ctrl.tick = cmd_fire && is_tick;
		assign ctrl.switch_on = cmd_fire && (cmd.operation == OP_ON)
			&& (cmd.channel == CH_W'(c));
		assign ctrl.switch_off = cmd_fire && (cmd.operation == OP_OFF)
			&& (cmd.channel == CH_W'(c));

		rdlc_channel u_channel (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.delay_ticks   (cmd.delay_ticks),
			.reclose_ticks (reclose_q),
			.drive_on      (on_vec[c]),
			.drive_off     (off_vec[c])
		);
	end

	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < CHANNELS) begin : g_used
			assign new_res.drive_on_mask[i] = is_tick && on_vec[i];
			assign new_res.drive_off_mask[i] = is_tick && off_vec[i];
		end else begin : g_unused
			assign new_res.drive_on_mask[i] = 1'b0;
			assign new_res.drive_off_mask[i] = 1'b0;
		end
	end
	assign new_res.bad_channel = bad_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!cmd_fire) begin
				res_valid_q <= 1'b0;
			end
		end else if (cmd_fire) begin
			if (res_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (cmd_fire) begin
				res_q <= new_res;
			end
		end else if (cmd_fire) begin
			if (res_valid_q) begin
				skid_q <= new_res;
			end else begin
				res_q <= new_res;
			end
		end
	end

	assign cmd_stall = skid_valid_q;
	assign res_valid = res_valid_q;
	assign res = res_q;

	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("Skid register holds an item while the result register is empty.");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid_q && res_stall))
		else $error("Skid register filled without a stalled result.");

	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.drive_on_mask & res_q.drive_off_mask) == '0))
		else $error("A channel is driven on and off in the same item.");

	a_bad_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.bad_channel) |->
		(res_q.drive_on_mask == '0 && res_q.drive_off_mask == '0))
		else $error("A rejected command reported drive bits.");

endmodule

>>> tb/tb_relay_delay_lockout_controller_unit.sv
// Self-checking testbench for the relay delay and lockout controller unit.
`timescale 1ns / 1ps

module tb_relay_delay_lockout_controller_unit;
	import rdlc_pkg::*;

	localparam int NCH = 8;
	localparam logic [1:0] OP_SPARE = 2'd3;

	class relay_scoreboard;
		bit chan_on[NCH];
		bit close_ok[NCH];
		bit [CNT_W-1:0] on_left[NCH];
		bit [CNT_W-1:0] off_left[NCH];
		bit [CNT_W-1:0] lock_left[NCH];
		bit [CNT_W-1:0] reclose_val;
		res_item_t due_q[$];
		int errors;

		function new();
			reclose_val = RECLOSE_RESET;
			errors = 0;
			foreach (chan_on[i]) begin
				chan_on[i] = 0;
				close_ok[i] = 0;
				on_left[i] = '0;
				off_left[i] = '0;
				lock_left[i] = '0;
			end
		endfunction

		function void set_reclose(bit [CNT_W-1:0] v);
			reclose_val = v;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_command(cmd_item_t c);
			res_item_t e;
			e = '0;
			case (c.operation)
				OP_TICK: begin
					for (int i = 0; i < NCH; i++) begin
						if (chan_on[i]) begin
							if (on_left[i] != 0)
								on_left[i]--;
							else if (close_ok[i])
								e.drive_on_mask[i] = 1'b1;
						end else begin
							if (off_left[i] != 0)
								off_left[i]--;
							else
								e.drive_off_mask[i] = 1'b1;
						end
						if (lock_left[i] != 0)
							lock_left[i]--;
						else
							close_ok[i] = 1;
					end
				end
				OP_ON, OP_OFF: begin
					if (c.channel >= NCH) begin
						e.bad_channel = 1'b1;
					end else if (c.operation == OP_ON) begin
						if (!chan_on[c.channel]) begin
							chan_on[c.channel] = 1;
							on_left[c.channel] = c.delay_ticks;
						end
					end else if (chan_on[c.channel]) begin
						lock_left[c.channel] = reclose_val;
						close_ok[c.channel] = 0;
						chan_on[c.channel] = 0;
						off_left[c.channel] = c.delay_ticks;
					end
				end
				default: ;
			endcase
			due_q.push_back(e);
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(res_item_t r);
			res_item_t e;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, r);
				errors++;
				return;
			end
			e = due_q.pop_front();
			if (r.drive_on_mask !== e.drive_on_mask)
				report("drive_on_mask", 16'(e.drive_on_mask), 16'(r.drive_on_mask));
			if (r.drive_off_mask !== e.drive_off_mask)
				report("drive_off_mask", 16'(e.drive_off_mask), 16'(r.drive_off_mask));
			if (r.bad_channel !== e.bad_channel)
				report("bad_channel", 16'(e.bad_channel), 16'(r.bad_channel));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic cmd_valid;
	logic cmd_stall;
	cmd_item_t cmd;
	logic res_valid;
	logic res_stall;
	res_item_t res;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	relay_scoreboard sb = new();

	relay_delay_lockout_controller_unit #(.CHANNELS(NCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd);
			if (res_valid && !res_stall)
				sb.check_result(res);
		end
	end

	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				hold_cycles--;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic cmd_item_t make_cmd(logic [1:0] op, logic [CH_W-1:0] ch,
			logic [CNT_W-1:0] d);
		cmd_item_t c;
		c.operation = op;
		c.channel = ch;
		c.delay_ticks = d;
		return c;
	endfunction

	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		int pick;
		int dsel;
		c.operation = OP_TICK;
		c.channel = CH_W'($urandom);
		c.delay_ticks = CNT_W'($urandom);
		pick = $urandom_range(99);
		dsel = $urandom_range(99);
		if (dsel < 80)
			c.delay_ticks = CNT_W'($urandom_range(4));
		else if (dsel < 95)
			c.delay_ticks = CNT_W'($urandom_range(20));
		if (pick < 50) begin
			c.operation = OP_TICK;
		end else if (pick < 90) begin
			c.operation = (pick < 70) ? OP_ON : OP_OFF;
			c.channel = CH_W'($urandom_range(NCH - 1));
		end else if (pick < 96) begin
			c.operation = $urandom_range(1) ? OP_ON : OP_OFF;
			c.channel = CH_W'($urandom_range(15, NCH));
		end else begin
			c.operation = OP_SPARE;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_cmd(random_cmd());
		cmd_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reclose(input logic [CNT_W-1:0] v);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reclose(v);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'hF, 16'hFFFF));
		send_cmd(make_cmd(OP_ON, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_ON, 4'd0, 16'h0005));
		send_cmd(make_cmd(OP_OFF, 4'd1, 16'h0003));
		send_cmd(make_cmd(OP_ON, 4'd3, 16'h0001));
		send_cmd(make_cmd(OP_OFF, 4'd0, 16'h0002));
		send_cmd(make_cmd(OP_OFF, 4'd0, 16'h0007));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_ON, 4'd8, 16'h0001));
		send_cmd(make_cmd(OP_OFF, 4'hF, 16'hFFFF));
		send_cmd(make_cmd(OP_SPARE, 4'd5, 16'hFFFF));
		send_cmd(make_cmd(OP_ON, 4'd7, 16'hFFFF));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_OFF, 4'd7, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_ON, 4'd7, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'h0000));
		cmd_valid <= 1'b0;

		write_reclose(16'h0000);
		send_idle_pct = 0;
		stall_pct = 0;
		send_random(400);
		hold_cycles = 80;
		send_random(30);
		wait_drained();
		send_random(50);

		write_reclose(16'hFFFF);
		send_idle_pct = 72;
		send_random(300);

		write_reclose(16'd3);
		send_idle_pct = 0;
		stall_pct = 72;
		send_random(400);

		write_reclose(16'($urandom_range(12, 1)));
		send_idle_pct = 14;
		stall_pct = 14;
		send_random(400);

		write_reclose(RECLOSE_RESET);
		send_random(100);

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
